// ----- rtl/htc_pkg.sv -----
// package: shared types, constants and codes of the hall threshold calibrator
package htc_pkg;

  // baseline limit and the widths that follow from it
  localparam int unsigned MaxBaselineSamples = 1024;
  localparam int unsigned LevelMax           = 1023;
  localparam int unsigned CntW               = $clog2(MaxBaselineSamples + 1);
  localparam int unsigned SumW               = $clog2(MaxBaselineSamples * LevelMax + 1);
  localparam int unsigned LvlW               = 10;
  localparam int unsigned CfgW               = 11;
  localparam int unsigned SpanCfgW           = 10;
  localparam int unsigned CfgIdxW            = 2;

  // divider step counter: one quotient bit per step over the sum width
  localparam int unsigned         DivStepW    = $clog2(SumW);
  localparam logic [DivStepW-1:0] DivLastStep = DivStepW'(SumW - 1);

  // reset values of the configuration registers
  localparam logic [CfgW-1:0]     MinBaselineReset = 11'd32;
  localparam logic [CfgW-1:0]     MaxBaselineReset = 11'd256;
  localparam logic [SpanCfgW-1:0] MinSpanReset     = 10'd20;

  // hysteresis clamp and saturation limits
  localparam logic [LvlW-1:0] HysMin      = 10'd5;
  localparam logic [LvlW-1:0] HysMax      = 10'd128;
  localparam logic [LvlW-1:0] LevelTop    = 10'd1023;
  localparam logic [15:0]     RunCountMax = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_CLEAR    = 3'd0,
    KIND_BASELINE = 3'd1,
    KIND_BEGIN    = 3'd2,
    KIND_RUN      = 3'd3,
    KIND_FINISH   = 3'd4,
    KIND_ANALYZE  = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_BASELINE = 2'd0,
    CFG_MAX_BASELINE = 2'd1,
    CFG_MIN_SPAN     = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_ANALYZE,
    ST_PROPOSE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] sample;
    logic [31:0] duration_ms;
    logic [15:0] summary_baseline;
    logic [15:0] summary_min;
    logic [15:0] summary_max;
    logic [15:0] summary_count;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        baseline_ready;
    logic        valid_res;
    logic        falling;
    logic [15:0] baseline_level;
    logic [15:0] min_level;
    logic [15:0] max_level;
    logic [9:0]  threshold;
    logic [7:0]  hysteresis;
    logic [15:0] run_samples;
    logic [31:0] duration_out;
  } res_t;

endpackage

// ----- rtl/htc_intf.sv -----
// interfaces: input item, result item and configuration write channels

interface htc_in_if;
  logic                valid;
  logic                ready;
  htc_pkg::in_item_t   item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface htc_out_if;
  logic            valid;
  logic            ready;
  htc_pkg::res_t   item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface htc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [htc_pkg::CfgIdxW-1:0]      index;
  logic [htc_pkg::CfgW-1:0]         data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/htc_div.sv -----
// restoring divider: baseline sum over baseline count, one quotient bit per cycle
module htc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [htc_pkg::SumW-1:0]   dividend_i,
  input  logic [htc_pkg::CntW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [htc_pkg::SumW-1:0]   quotient_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [htc_pkg::DivStepW-1:0]   step_q, step_d;
  logic [htc_pkg::CntW-1:0]       rem_q, rem_d;
  logic [htc_pkg::SumW-1:0]       quo_q, quo_d;
  logic [htc_pkg::CntW-1:0]       dvs_q, dvs_d;
  logic [htc_pkg::CntW:0]         shifted;
  logic [htc_pkg::CntW:0]         trial;

  // trial subtraction of the shifted remainder
  assign shifted = {rem_q, quo_q[htc_pkg::SumW-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[htc_pkg::CntW]) begin
        rem_d = shifted[htc_pkg::CntW-1:0];
      end else begin
        rem_d = trial[htc_pkg::CntW-1:0];
      end
      quo_d  = {quo_q[htc_pkg::SumW-2:0], ~trial[htc_pkg::CntW]};
      step_d = step_q + htc_pkg::DivStepW'(1);
      if (step_q == htc_pkg::DivLastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/hall_threshold_calibrator.sv -----
// top level: hall sensor threshold calibrator with item sequencer and divider
// clear, baseline, begin-run, run-sample, spare kinds and finish without a ready baseline go
//   from execute straight to done; analyze goes through analyze and, unless rejected, propose;
//   finish with a ready baseline first runs the bit-serial divider (one quotient bit per cycle
//   over the sum width) and then goes on as analyze does
// items are handled one at a time; the next item is taken in the cycle after the result is registered
// reset: registers return to 32, 256 and 20; statistics clear; no memory sweep needed
module hall_threshold_calibrator (
  input  logic       clk_i,
  input  logic       rst_ni,
  htc_in_if.sink     in_i,
  htc_out_if.source  out_o,
  htc_cfg_if.sink    cfg_i
);

  htc_pkg::state_e state_q, state_d;

  // configuration registers
  logic [htc_pkg::CfgW-1:0]     min_base_q, max_base_q;
  logic [htc_pkg::SpanCfgW-1:0] min_span_q;

  // accumulated statistics
  logic [htc_pkg::SumW-1:0] sum_q;
  logic [htc_pkg::CntW-1:0] bcount_q;
  logic [9:0]               run_min_q, run_max_q;
  logic [15:0]              run_count_q;

  // item under work
  htc_pkg::in_item_t item_q;
  htc_pkg::res_t     work_q;
  htc_pkg::res_t     done_res;
  htc_pkg::res_t     out_q;
  logic              out_valid_q;
  logic [15:0]       base_q, lo_q, hi_q, cnt_q;
  logic [9:0]        span_q;

  logic                     div_start, div_done;
  logic [htc_pkg::SumW-1:0] quotient;

  logic in_fire, out_slot_free, cfg_fire;
  logic is_ready, sample_ok, below_limit;

  // analysis datapath
  logic        reject, rising;
  logic [9:0]  up, down, span;
  logic [10:0] thr_raw;
  logic [9:0]  thr, hys_a, hys_b, hys;
  logic        prop_ok;

  assign in_fire       = in_i.valid & in_i.ready;
  assign cfg_fire      = cfg_i.valid & cfg_i.ready;
  assign out_slot_free = ~out_valid_q | out_o.ready;
  assign cfg_i.ready   = 1'b1;

  assign is_ready = (bcount_q != '0) && (32'(bcount_q) >= 32'(min_base_q));
  assign sample_ok = (item_q.sample[15:10] == '0);

  // effective baseline limit is the smaller of the register and the storage bound
  always_comb begin
    if (32'(max_base_q) > htc_pkg::MaxBaselineSamples) begin
      below_limit = 32'(bcount_q) < htc_pkg::MaxBaselineSamples;
    end else begin
      below_limit = 32'(bcount_q) < 32'(max_base_q);
    end
  end

  htc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (bcount_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      htc_pkg::ST_IDLE: begin
        if (in_fire) state_d = htc_pkg::ST_EXEC;
      end
      htc_pkg::ST_EXEC: begin
        if (htc_pkg::kind_e'(item_q.kind) == htc_pkg::KIND_FINISH && is_ready) begin
          state_d = htc_pkg::ST_DIV;
        end else if (htc_pkg::kind_e'(item_q.kind) == htc_pkg::KIND_ANALYZE) begin
          state_d = htc_pkg::ST_ANALYZE;
        end else begin
          state_d = htc_pkg::ST_DONE;
        end
      end
      htc_pkg::ST_DIV: begin
        if (div_done) state_d = htc_pkg::ST_ANALYZE;
      end
      htc_pkg::ST_ANALYZE: begin
        if (reject || span < min_span_q) state_d = htc_pkg::ST_DONE;
        else                             state_d = htc_pkg::ST_PROPOSE;
      end
      htc_pkg::ST_PROPOSE: state_d = htc_pkg::ST_DONE;
      htc_pkg::ST_DONE: begin
        if (out_slot_free) state_d = htc_pkg::ST_IDLE;
      end
      default: state_d = htc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      htc_pkg::ST_IDLE: in_i.ready = 1'b1;
      htc_pkg::ST_EXEC: begin
        div_start = (htc_pkg::kind_e'(item_q.kind) == htc_pkg::KIND_FINISH) && is_ready;
      end
      default: begin
        in_i.ready = 1'b0;
        div_start  = 1'b0;
      end
    endcase
  end

  // swing in each direction and the larger one
  always_comb begin
    reject = (base_q[15:10] != '0) || (lo_q[15:10] != '0) || (hi_q[15:10] != '0) ||
             (cnt_q == '0) || (hi_q < lo_q);
    up     = (hi_q[9:0] > base_q[9:0]) ? hi_q[9:0] - base_q[9:0] : '0;
    down   = (base_q[9:0] > lo_q[9:0]) ? base_q[9:0] - lo_q[9:0] : '0;
    rising = up >= down;
    span   = rising ? up : down;
  end

  // threshold at half span, hysteresis at a quarter span, clamped
  always_comb begin
    if (!work_q.falling) begin
      thr_raw = {1'b0, base_q[9:0]} + {2'b00, span_q[9:1]};
    end else begin
      thr_raw = {1'b0, base_q[9:0]} - {2'b00, span_q[9:1]};
    end
    if (thr_raw == '0)            thr = 10'd1;
    else if (thr_raw[10])         thr = htc_pkg::LevelTop;
    else                          thr = thr_raw[9:0];
    hys_a = {2'b00, span_q[9:2]};
    if (hys_a < htc_pkg::HysMin)      hys_b = htc_pkg::HysMin;
    else if (hys_a > htc_pkg::HysMax) hys_b = htc_pkg::HysMax;
    else                              hys_b = hys_a;
    if (hys_b >= thr) hys = (thr > 10'd1) ? thr - 10'd1 : 10'd1;
    else              hys = hys_b;
    prop_ok = (hys != '0) && (hys < thr);
  end

  // result as it leaves, with the readiness after this item
  always_comb begin
    done_res                = work_q;
    done_res.baseline_ready = is_ready;
  end

  // control state: sequencer, configuration, statistics, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htc_pkg::ST_IDLE;
      min_base_q  <= htc_pkg::MinBaselineReset;
      max_base_q  <= htc_pkg::MaxBaselineReset;
      min_span_q  <= htc_pkg::MinSpanReset;
      sum_q       <= '0;
      bcount_q    <= '0;
      run_min_q   <= htc_pkg::LevelTop;
      run_max_q   <= '0;
      run_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        case (htc_pkg::cfg_reg_e'(cfg_i.index))
          htc_pkg::CFG_MIN_BASELINE: min_base_q <= cfg_i.data;
          htc_pkg::CFG_MAX_BASELINE: max_base_q <= cfg_i.data;
          htc_pkg::CFG_MIN_SPAN:     min_span_q <= cfg_i.data[htc_pkg::SpanCfgW-1:0];
          default:                   ;
        endcase
      end
      // statistics update of the item in hand
      if (state_q == htc_pkg::ST_EXEC) begin
        case (htc_pkg::kind_e'(item_q.kind))
          htc_pkg::KIND_CLEAR: begin
            sum_q       <= '0;
            bcount_q    <= '0;
            run_min_q   <= htc_pkg::LevelTop;
            run_max_q   <= '0;
            run_count_q <= '0;
          end
          htc_pkg::KIND_BASELINE: begin
            if (sample_ok && below_limit) begin
              sum_q    <= sum_q + htc_pkg::SumW'(item_q.sample[9:0]);
              bcount_q <= bcount_q + htc_pkg::CntW'(1);
            end
          end
          htc_pkg::KIND_BEGIN: begin
            run_min_q   <= htc_pkg::LevelTop;
            run_max_q   <= '0;
            run_count_q <= '0;
          end
          htc_pkg::KIND_RUN: begin
            if (sample_ok) begin
              if (item_q.sample[9:0] < run_min_q) run_min_q <= item_q.sample[9:0];
              if (item_q.sample[9:0] > run_max_q) run_max_q <= item_q.sample[9:0];
              if (run_count_q != htc_pkg::RunCountMax) run_count_q <= run_count_q + 16'd1;
            end
          end
          default: ;
        endcase
      end
      if (state_q == htc_pkg::ST_DONE && out_slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and result build-up
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i.item;
      work_q <= '0;
    end
    case (state_q)
      htc_pkg::ST_EXEC: begin
        case (htc_pkg::kind_e'(item_q.kind))
          htc_pkg::KIND_BASELINE: work_q.accepted <= sample_ok && below_limit;
          htc_pkg::KIND_FINISH: begin
            lo_q                <= 16'(run_min_q);
            hi_q                <= 16'(run_max_q);
            cnt_q               <= run_count_q;
            work_q.run_samples  <= run_count_q;
            work_q.duration_out <= item_q.duration_ms;
          end
          htc_pkg::KIND_ANALYZE: begin
            base_q              <= item_q.summary_baseline;
            lo_q                <= item_q.summary_min;
            hi_q                <= item_q.summary_max;
            cnt_q               <= item_q.summary_count;
            work_q.run_samples  <= item_q.summary_count;
            work_q.duration_out <= item_q.duration_ms;
          end
          default: ;
        endcase
      end
      htc_pkg::ST_DIV: begin
        if (div_done) base_q <= quotient[15:0];
      end
      htc_pkg::ST_ANALYZE: begin
        work_q.baseline_level <= base_q;
        work_q.min_level      <= lo_q;
        work_q.max_level      <= hi_q;
        work_q.falling        <= ~reject & ~rising;
        span_q                <= span;
      end
      htc_pkg::ST_PROPOSE: begin
        work_q.valid_res <= prop_ok;
        if (prop_ok) begin
          work_q.threshold  <= thr;
          work_q.hysteresis <= hys[7:0];
        end
      end
      htc_pkg::ST_DONE: begin
        if (out_slot_free) begin
          out_q <= done_res;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

endmodule
